### hdl/dqsh_pkg.sv
package dqsh_pkg;

  // FNV-1a 64 offset basis; the prime 0x100000001b3 is applied as shifts in fnv_mix
  localparam logic [63:0] FNV_OFFSET = 64'hcbf2_9ce4_8422_2325;

  localparam int DEFAULT_SCAN_LIMIT = 64;

  // byte classes
  localparam logic [7:0] LEN_MAX = 8'd63;
  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    STATUS_TERM  = 2'd0,
    STATUS_TRUNC = 2'd1,
    STATUS_LIMIT = 2'd2
  } scan_status_t;

  // hash state carried between bytes
  typedef struct packed {
    logic [63:0] whole;
    logic [63:0] one_label;
    logic [63:0] two_label;
    logic        seen_len;
    logic        active;
  } hash_state_t;

  // result produced by one byte
  typedef struct packed {
    logic         emit;
    scan_status_t status;
    logic [63:0]  whole;
    logic [63:0]  one_label;
    logic [63:0]  two_label;
  } step_result_t;

  // one FNV-1a round: xor byte, multiply by 2^40 + 0x1b3 as a shift-add
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### hdl/dns_qname_suffix_hasher_top.sv
// Channel | Signals                                            | Direction
// input   | in_valid, in_stall, first_byte, name_byte,         | in (stall out)
//         | packet_ended                                       |
// output  | out_valid, out_stall, scan_status, full_name_hash, | out (stall in)
//         | last_label_hash, last_two_labels_hash              |
// One byte per cycle sustained while the result is not stalled. An accepted
// byte sits in an input register, and the three FNV rounds run as shift-add
// logic from it into the state and result registers. rst is synchronous and
// clears the scan, the input register and the result register. A stalled
// result holds; the byte behind it then waits in the input register and
// in_stall rises only while both registers are full.
module dns_qname_suffix_hasher_top import dqsh_pkg::*; #(
  parameter int SCAN_LIMIT = DEFAULT_SCAN_LIMIT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         first_byte,
  input  logic [7:0]   name_byte,
  input  logic         packet_ended,
  output logic         out_valid,
  input  logic         out_stall,
  output scan_status_t scan_status,
  output logic [63:0]  full_name_hash,
  output logic [63:0]  last_label_hash,
  output logic [63:0]  last_two_labels_hash
);

  localparam int CNT_W = $clog2(SCAN_LIMIT + 1);

  logic             in_full;
  logic             hold_first;
  logic [7:0]       hold_byte;
  logic             hold_ended;
  hash_state_t      state;
  hash_state_t      state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  step_result_t     res;
  logic             out_free;
  logic             fire;

  assign out_free = !out_valid || !out_stall;
  assign fire = in_full && out_free;
  assign in_stall = in_full && !out_free;

  // capture the input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_first <= first_byte;
      hold_byte <= name_byte;
      hold_ended <= packet_ended;
    end
  end

  dqsh_step #(
    .SCAN_LIMIT(SCAN_LIMIT),
    .CNT_W(CNT_W)
  ) u_step (
    .cur(state),
    .cur_count(count),
    .first_byte(hold_first),
    .name_byte(hold_byte),
    .packet_ended(hold_ended),
    .nxt(state_next),
    .nxt_count(count_next),
    .res(res)
  );

  // advance the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.whole <= FNV_OFFSET;
      state.one_label <= 64'd0;
      state.two_label <= 64'd0;
      state.seen_len <= 1'b0;
      state.active <= 1'b0;
      count <= '0;
    end else if (fire) begin
      state <= state_next;
      count <= count_next;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      scan_status <= res.status;
      full_name_hash <= res.whole;
      last_label_hash <= res.one_label;
      last_two_labels_hash <= res.two_label;
    end
  end

endmodule

### hdl/dqsh_step.sv
module dqsh_step import dqsh_pkg::*; #(
  parameter int SCAN_LIMIT = DEFAULT_SCAN_LIMIT,
  parameter int CNT_W = $clog2(SCAN_LIMIT + 1)
) (
  input  hash_state_t      cur,
  input  logic [CNT_W-1:0] cur_count,
  input  logic             first_byte,
  input  logic [7:0]       name_byte,
  input  logic             packet_ended,
  output hash_state_t      nxt,
  output logic [CNT_W-1:0] nxt_count,
  output step_result_t     res
);

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(SCAN_LIMIT);

  hash_state_t      base;
  hash_state_t      upd;
  logic [CNT_W-1:0] base_count;
  logic [CNT_W-1:0] inc_count;
  logic [7:0]       low_byte;
  logic [63:0]      two_moved;

  // restart on the first byte of a name
  always_comb begin
    if (first_byte) begin
      base.whole = FNV_OFFSET;
      base.one_label = 64'd0;
      base.two_label = 64'd0;
      base.seen_len = 1'b0;
      base.active = 1'b1;
      base_count = '0;
    end else begin
      base = cur;
      base_count = cur_count;
    end
  end

  // fold upper case letters
  assign low_byte = (name_byte >= UPPER_A && name_byte <= UPPER_Z) ?
                    name_byte + CASE_OFFSET : name_byte;
  assign inc_count = base_count + CNT_W'(1);
  assign two_moved = base.one_label;

  // hash update for a non-zero byte
  always_comb begin
    upd = base;
    if (name_byte <= LEN_MAX && !base.seen_len) begin
      upd.seen_len = 1'b1;
    end else if (name_byte <= LEN_MAX) begin
      upd.one_label = FNV_OFFSET;
      upd.whole = fnv_mix(base.whole, CHAR_DOT);
      if (two_moved != 64'd0 && two_moved != FNV_OFFSET) begin
        upd.two_label = fnv_mix(two_moved, CHAR_DOT);
      end else begin
        upd.two_label = two_moved;
      end
    end else begin
      upd.whole = fnv_mix(base.whole, low_byte);
      if (base.one_label != 64'd0) begin
        upd.one_label = fnv_mix(base.one_label, low_byte);
      end
      if (base.two_label != 64'd0) begin
        upd.two_label = fnv_mix(base.two_label, low_byte);
      end
    end
  end

  // pick end of scan and next state
  always_comb begin
    nxt = base;
    nxt_count = base_count;
    res.emit = 1'b0;
    res.status = STATUS_TERM;
    res.whole = base.whole;
    res.one_label = base.one_label;
    res.two_label = base.two_label;
    if (base.active) begin
      if (packet_ended) begin
        res.emit = 1'b1;
        res.status = STATUS_TRUNC;
        nxt.active = 1'b0;
      end else if (name_byte == 8'd0) begin
        res.emit = 1'b1;
        res.status = STATUS_TERM;
        nxt.active = 1'b0;
      end else begin
        nxt = upd;
        nxt_count = inc_count;
        res.whole = upd.whole;
        res.one_label = upd.one_label;
        res.two_label = upd.two_label;
        if (inc_count >= LIMIT) begin
          res.emit = 1'b1;
          res.status = STATUS_LIMIT;
          nxt.active = 1'b0;
        end
      end
    end
  end

endmodule

### hdl/dqsh_checker.sv
module dqsh_checker import dqsh_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input scan_status_t scan_status,
  input logic [63:0]  full_name_hash,
  input logic [63:0]  last_label_hash,
  input logic [63:0]  last_two_labels_hash
);

  // reset empties both registers
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // input backs up only behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result slot free");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scan_status) &&
      $stable(full_name_hash) && $stable(last_label_hash) &&
      $stable(last_two_labels_hash))
    else $error("stalled result changed");

  // status code stays in range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scan_status == STATUS_TERM || scan_status == STATUS_TRUNC ||
      scan_status == STATUS_LIMIT)
    else $error("bad scan status");

endmodule

bind dns_qname_suffix_hasher_top dqsh_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .scan_status(scan_status),
  .full_name_hash(full_name_hash),
  .last_label_hash(last_label_hash),
  .last_two_labels_hash(last_two_labels_hash)
);
